// ----- rtl/core/athr_pkg.sv -----
// Shared types and constants for the adaptive threshold heart rate unit.
// Used by athr_ctrl, athr_dp and the top level; depends on nothing.
package athr_pkg;

    // Field and register widths.
    localparam int SAMPLE_W = 18;
    localparam int TIME_W   = 32;
    localparam int IVAL_W   = 16;
    localparam int RATE_W   = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 18;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_PRESENCE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_IVAL = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_IVAL = 2'd2;

    // Reset values.
    localparam logic [SAMPLE_W-1:0] PRESENCE_RST  = 18'd50000;
    localparam logic [IVAL_W-1:0]   MIN_IVAL_RST  = 16'd300;
    localparam logic [IVAL_W-1:0]   MAX_IVAL_RST  = 16'd2000;
    localparam logic [SAMPLE_W-1:0] THRESHOLD_RST = 18'd100000;

    // Threshold filter: (thr * 99 + sample) / 100.
    localparam int ACC_W = 25;
    localparam logic [ACC_W-1:0] THR_WEIGHT = 25'd99;
    // ceil(2^32 / 100); exact quotient for every dividend below 2^25.
    localparam int RECIP_W     = 26;
    localparam int RECIP_SHIFT = 32;
    localparam logic [RECIP_W-1:0] RECIP_100 = 26'd42949673;
    localparam int PROD_W = ACC_W + RECIP_W;

    // Rate divider: 60000 / interval, one quotient bit per cycle.
    localparam logic [RATE_W-1:0] RATE_NUMER = 16'd60000;
    localparam int DIV_STEPS = RATE_W;
    localparam int DIV_CNT_W = 4;
    localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_STEPS - 1);

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_in;
        logic eval;
        logic mul;
        logic div_step;
        logic commit;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic div_done;
    } status_t;

endpackage

// ----- rtl/core/adaptive_threshold_heart_rate_unit.sv -----
// Top level of the adaptive threshold heart rate unit: a new sample is taken only
// once the previous one is committed, and the rate comes from the 16-step
// restoring divider for 60000 / interval.
// The next item is accepted while the previous result still waits.
// Reset (rst_n, async, active low) loads register defaults, threshold 100000
// and last beat time zero. Instantiates athr_ctrl and athr_dp; uses athr_pkg.
module adaptive_threshold_heart_rate_unit
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [athr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [athr_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [athr_pkg::SAMPLE_W-1:0]   ir_sample,
    input  logic [athr_pkg::TIME_W-1:0]     time_ms,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [athr_pkg::RATE_W-1:0]     rate_bpm,
    output logic                            beat_found
);

    athr_pkg::cmd_t    cmd;
    athr_pkg::status_t status;

    // Configuration transactions are always taken.
    assign cfg_ready = 1'b1;

    athr_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    athr_dp u_dp
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (status),
        .cfg_write  (cfg_valid),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .ir_sample  (ir_sample),
        .time_ms    (time_ms),
        .rate_bpm   (rate_bpm),
        .beat_found (beat_found)
    );

endmodule

// ----- rtl/core/athr_ctrl.sv -----
// Controller state machine for the adaptive threshold heart rate unit.
// Depends on athr_pkg; drives the athr_dp command struct and the handshakes.
module athr_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    input  athr_pkg::status_t status,
    output athr_pkg::cmd_t    cmd
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_EVAL = 5'b00010,
        S_MUL  = 5'b00100,
        S_DIV  = 5'b01000,
        S_DONE = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   slot_free;

    // The result register can take a new result when empty or being drained.
    assign slot_free = !out_valid_reg || out_ready;

    // Next state and command decode.
    always_comb
    begin
        state_next   = state_reg;
        cmd          = '0;
        in_ready     = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.load_in = in_valid;
                if (in_valid)
                begin
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                cmd.eval   = 1'b1;
                state_next = S_MUL;
            end
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (status.div_done)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (slot_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Output valid: set on commit, cleared when the transaction completes.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (cmd.commit)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    // A commit never overwrites a result that is still waiting.
    a_commit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit && out_valid_reg |-> out_ready)
        else $error("commit overwrote a pending result");

    // The last divider step always leads to the commit state.
    a_div_exit: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DIV && status.div_done |=> state_reg == S_DONE)
        else $error("divider exit missed");

    // A new item is taken only when the previous one has been committed.
    a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_in |=> state_reg == S_EVAL && !cmd.commit)
        else $error("accept outside idle");

endmodule

// ----- rtl/core/athr_dp.sv -----
// Datapath for the adaptive threshold heart rate unit: configuration,
// threshold filter, beat window test and iterative rate divider. Uses athr_pkg.
module athr_dp
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  athr_pkg::cmd_t                      cmd,
    output athr_pkg::status_t                   status,
    input  logic                                cfg_write,
    input  logic [athr_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [athr_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic [athr_pkg::SAMPLE_W-1:0]       ir_sample,
    input  logic [athr_pkg::TIME_W-1:0]         time_ms,
    output logic [athr_pkg::RATE_W-1:0]         rate_bpm,
    output logic                                beat_found
);

    // Configuration registers.
    logic [athr_pkg::SAMPLE_W-1:0] presence_reg;
    logic [athr_pkg::IVAL_W-1:0]   min_ival_reg;
    logic [athr_pkg::IVAL_W-1:0]   max_ival_reg;

    // Detector state.
    logic [athr_pkg::SAMPLE_W-1:0] thr_reg;
    logic [athr_pkg::TIME_W-1:0]   last_beat_reg;

    // Per-item working registers.
    logic [athr_pkg::SAMPLE_W-1:0] sample_reg;
    logic [athr_pkg::TIME_W-1:0]   time_reg;
    logic                          present_reg;
    logic                          beat_reg;
    logic [athr_pkg::ACC_W-1:0]    acc_reg;
    logic [athr_pkg::SAMPLE_W-1:0] thr_new_reg;
    logic [athr_pkg::IVAL_W-1:0]   divisor_reg;
    logic [athr_pkg::RATE_W-1:0]   quo_reg;
    logic [athr_pkg::RATE_W-1:0]   rem_reg;
    logic [athr_pkg::DIV_CNT_W-1:0] cnt_reg;

    // Result registers.
    logic [athr_pkg::RATE_W-1:0]   rate_reg;
    logic                          found_reg;

    logic [athr_pkg::TIME_W-1:0]   delta;
    logic                          present;
    logic                          in_window;
    logic [athr_pkg::PROD_W-1:0]   prod;
    logic [athr_pkg::RATE_W:0]     rem_sh;
    logic                          rem_ge;
    logic [athr_pkg::RATE_W:0]     rem_sub;

    // Configuration writes; an index beyond the list is ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            presence_reg <= athr_pkg::PRESENCE_RST;
            min_ival_reg <= athr_pkg::MIN_IVAL_RST;
            max_ival_reg <= athr_pkg::MAX_IVAL_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                athr_pkg::CFG_PRESENCE: presence_reg <= cfg_data;
                athr_pkg::CFG_MIN_IVAL: min_ival_reg <= cfg_data[athr_pkg::IVAL_W-1:0];
                athr_pkg::CFG_MAX_IVAL: max_ival_reg <= cfg_data[athr_pkg::IVAL_W-1:0];
                default: ;
            endcase
        end
    end

    // Presence, threshold and interval window tests.
    assign delta     = time_reg - last_beat_reg;
    assign present   = sample_reg > presence_reg;
    assign in_window = (delta > {16'd0, min_ival_reg}) && (delta < {16'd0, max_ival_reg});

    // Second filter stage: divide by 100 through the reciprocal.
    assign prod = {{athr_pkg::RECIP_W{1'b0}}, acc_reg}
                * {{athr_pkg::ACC_W{1'b0}}, athr_pkg::RECIP_100};

    // One restoring division step.
    assign rem_sh  = {rem_reg, quo_reg[athr_pkg::RATE_W-1]};
    assign rem_ge  = rem_sh >= {1'b0, divisor_reg};
    assign rem_sub = rem_sh - {1'b0, divisor_reg};

    assign status.div_done = cnt_reg == athr_pkg::DIV_LAST;

    // Item working registers.
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            sample_reg <= ir_sample;
            time_reg   <= time_ms;
        end
        if (cmd.eval)
        begin
            present_reg <= present;
            beat_reg    <= present && (sample_reg > thr_reg) && in_window;
            divisor_reg <= delta[athr_pkg::IVAL_W-1:0];
            acc_reg     <= {7'd0, thr_reg} * athr_pkg::THR_WEIGHT
                         + {7'd0, sample_reg};
            quo_reg     <= athr_pkg::RATE_NUMER;
            rem_reg     <= '0;
        end
        if (cmd.mul)
        begin
            thr_new_reg <= prod[athr_pkg::RECIP_SHIFT +: athr_pkg::SAMPLE_W];
        end
        if (cmd.div_step)
        begin
            quo_reg <= {quo_reg[athr_pkg::RATE_W-2:0], rem_ge};
            rem_reg <= rem_ge ? rem_sub[athr_pkg::RATE_W-1:0] : rem_sh[athr_pkg::RATE_W-1:0];
        end
    end

    // Divider step counter.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (cmd.eval)
        begin
            cnt_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            cnt_reg <= cnt_reg + 1'b1;
        end
    end

    // Detector state update and result load on commit.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg       <= athr_pkg::THRESHOLD_RST;
            last_beat_reg <= '0;
        end
        else if (cmd.commit)
        begin
            if (present_reg)
            begin
                thr_reg <= thr_new_reg;
            end
            if (beat_reg)
            begin
                last_beat_reg <= time_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            rate_reg  <= beat_reg ? quo_reg : '0;
            found_reg <= beat_reg;
        end
    end

    assign rate_bpm   = rate_reg;
    assign beat_found = found_reg;

    // An accepted beat always has a nonzero interval to divide by.
    a_divisor_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit && beat_reg |-> divisor_reg != '0)
        else $error("beat with zero interval");

    // The rate can never exceed the numerator.
    a_rate_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit && beat_reg |-> quo_reg <= athr_pkg::RATE_NUMER)
        else $error("rate out of range");

    // A beat requires a finger to be present.
    a_beat_present: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit && beat_reg |-> present_reg)
        else $error("beat without presence");

endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for adaptive_threshold_heart_rate_unit.
// Needs athr_pkg and the unit's RTL; a built-in beat predictor checks every result.
module testbench;

    // Run limits, in clock cycles.
    localparam int LIMIT_CYCLES = 400000;
    localparam int DRAIN_CYCLES = 40;
    localparam int HOLD_CYCLES  = 400;
    localparam int PHASES       = 8;

    // Register index with no register behind it.
    localparam logic [athr_pkg::CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    localparam logic [athr_pkg::SAMPLE_W-1:0] SAMPLE_MAX = 18'h3FFFF;

    typedef logic [athr_pkg::SAMPLE_W-1:0]   sample_t;
    typedef logic [athr_pkg::RATE_W-1:0]     rate_t;
    typedef logic [athr_pkg::CFG_DATA_W-1:0] cfg_word_t;

    typedef struct packed {
        logic [athr_pkg::RATE_W-1:0] rate;
        logic                        found;
    } beat_result_t;

    typedef enum logic {ROW_SAMPLE, ROW_REG} row_kind_t;

    // One directed step: a sample transaction or a register write.
    typedef struct packed {
        row_kind_t                         kind;
        logic [athr_pkg::CFG_IDX_W-1:0]    idx;
        logic [athr_pkg::CFG_DATA_W-1:0]   value;
        logic [athr_pkg::TIME_W-1:0]       stamp;
        logic                              known;
        logic [athr_pkg::RATE_W-1:0]       rate;
        logic                              found;
    } row_t;

    logic                            clk;
    logic                            rst_n;
    logic                            cfg_valid;
    logic                            cfg_ready;
    logic [athr_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [athr_pkg::CFG_DATA_W-1:0] cfg_data;
    logic                            in_valid;
    logic                            in_ready;
    logic [athr_pkg::SAMPLE_W-1:0]   ir_sample;
    logic [athr_pkg::TIME_W-1:0]     time_ms;
    logic                            out_valid;
    logic                            out_ready;
    logic [athr_pkg::RATE_W-1:0]     rate_bpm;
    logic                            beat_found;

    // Predictor copy of the registers and the detector state.
    logic [athr_pkg::SAMPLE_W-1:0] presence_cfg;
    logic [athr_pkg::IVAL_W-1:0]   min_gap_cfg;
    logic [athr_pkg::IVAL_W-1:0]   max_gap_cfg;
    logic [athr_pkg::SAMPLE_W-1:0] thr_level;
    logic [athr_pkg::TIME_W-1:0]   last_beat;

    beat_result_t expected_beats[$];
    beat_result_t head_beat;

    int unsigned cycle_count;
    int unsigned fail_count;
    int unsigned items_sent;
    int unsigned beats_seen;
    int unsigned reg_writes;
    int unsigned idle_pct;
    bit          hold_req;

    // Directed steps, starting from the reset state. Sample rows ignore idx.
    row_t directed_rows [22] = '{
        // No finger, then a sample equal to the presence level.
        '{ROW_SAMPLE, CFG_SPARE, 18'd0,      32'd0,          1'b1, 16'd0,     1'b0},
        '{ROW_SAMPLE, CFG_SPARE, 18'd50000,  32'd1000,       1'b1, 16'd0,     1'b0},
        // Full-scale peak, one second after the reset beat time.
        '{ROW_SAMPLE, CFG_SPARE, SAMPLE_MAX, 32'd1000,       1'b1, 16'd60,    1'b1},
        // Interval equal to the minimum, then one past it.
        '{ROW_SAMPLE, CFG_SPARE, SAMPLE_MAX, 32'd1300,       1'b1, 16'd0,     1'b0},
        '{ROW_SAMPLE, CFG_SPARE, SAMPLE_MAX, 32'd1301,       1'b0, 16'd0,     1'b0},
        // Interval equal to the maximum, then one below it.
        '{ROW_SAMPLE, CFG_SPARE, SAMPLE_MAX, 32'd3301,       1'b1, 16'd0,     1'b0},
        '{ROW_SAMPLE, CFG_SPARE, SAMPLE_MAX, 32'd3300,       1'b0, 16'd0,     1'b0},
        // Time going backward wraps to a huge interval.
        '{ROW_SAMPLE, CFG_SPARE, SAMPLE_MAX, 32'd3000,       1'b1, 16'd0,     1'b0},
        // Finger present but below the threshold.
        '{ROW_SAMPLE, CFG_SPARE, 18'd60000,  32'd4000,       1'b1, 16'd0,     1'b0},
        '{ROW_SAMPLE, CFG_SPARE, SAMPLE_MAX, 32'hFFFF_FFFF,  1'b1, 16'd0,     1'b0},
        // Zero presence level and a window that only takes an interval of one.
        '{ROW_REG,    athr_pkg::CFG_PRESENCE, 18'd0, 32'd0,  1'b0, 16'd0,     1'b0},
        '{ROW_REG,    athr_pkg::CFG_MIN_IVAL, 18'd0, 32'd0,  1'b0, 16'd0,     1'b0},
        '{ROW_REG,    athr_pkg::CFG_MAX_IVAL, 18'd2, 32'd0,  1'b0, 16'd0,     1'b0},
        '{ROW_SAMPLE, CFG_SPARE, SAMPLE_MAX, 32'd3301,       1'b1, 16'd60000, 1'b1},
        '{ROW_SAMPLE, CFG_SPARE, 18'd0,      32'd3302,       1'b1, 16'd0,     1'b0},
        '{ROW_SAMPLE, CFG_SPARE, SAMPLE_MAX, 32'd3301,       1'b1, 16'd0,     1'b0},
        // Oversized writes are cut to 16 bits, leaving an empty window.
        '{ROW_REG,    athr_pkg::CFG_MIN_IVAL, SAMPLE_MAX, 32'd0, 1'b0, 16'd0, 1'b0},
        '{ROW_REG,    athr_pkg::CFG_MAX_IVAL, SAMPLE_MAX, 32'd0, 1'b0, 16'd0, 1'b0},
        '{ROW_SAMPLE, CFG_SPARE, SAMPLE_MAX, 32'd3400,       1'b1, 16'd0,     1'b0},
        // Unmapped index, then a presence level that no sample can exceed.
        '{ROW_REG,    CFG_SPARE,    18'h2AAAA, 32'd0,        1'b0, 16'd0,     1'b0},
        '{ROW_REG,    athr_pkg::CFG_PRESENCE, SAMPLE_MAX, 32'd0, 1'b0, 16'd0, 1'b0},
        '{ROW_SAMPLE, CFG_SPARE, SAMPLE_MAX, 32'd5000,       1'b1, 16'd0,     1'b0}
    };

    adaptive_threshold_heart_rate_unit uut
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .ir_sample  (ir_sample),
        .time_ms    (time_ms),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .rate_bpm   (rate_bpm),
        .beat_found (beat_found)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #10 clk = ~clk;

    // Beat decision for one sample; advances the predictor state.
    function automatic beat_result_t detect_beat(input logic [athr_pkg::SAMPLE_W-1:0] sample,
                                                 input logic [athr_pkg::TIME_W-1:0] stamp);
        beat_result_t res;
        logic [athr_pkg::TIME_W-1:0] gap;
        int unsigned mix;
        res = '0;
        if (sample > presence_cfg)
        begin
            if (sample > thr_level)
            begin
                gap = stamp - last_beat;
                if (gap > min_gap_cfg && gap < max_gap_cfg)
                begin
                    res.rate  = rate_t'(60000 / gap);
                    res.found = 1'b1;
                    last_beat = stamp;
                end
            end
            mix = thr_level * 99 + sample;
            thr_level = sample_t'(mix / 100);
        end
        return res;
    endfunction

    // Lowers the sample valid and waits until every pending result is out.
    task automatic drain_results();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (expected_beats.size() != 0);
    endtask

    // Register write, issued only while the unit is idle.
    task automatic write_reg(input logic [athr_pkg::CFG_IDX_W-1:0] idx,
                             input logic [athr_pkg::CFG_DATA_W-1:0] data);
        drain_results();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            athr_pkg::CFG_PRESENCE: presence_cfg = data;
            athr_pkg::CFG_MIN_IVAL: min_gap_cfg  = data[athr_pkg::IVAL_W-1:0];
            athr_pkg::CFG_MAX_IVAL: max_gap_cfg  = data[athr_pkg::IVAL_W-1:0];
            default: ;
        endcase
        cfg_valid <= 1'b0;
        reg_writes++;
    endtask

    // Offers one sample transaction and records its expected result on acceptance.
    task automatic push_sample(input logic [athr_pkg::SAMPLE_W-1:0] sample,
                               input logic [athr_pkg::TIME_W-1:0] stamp,
                               input logic known,
                               input logic [athr_pkg::RATE_W-1:0] known_rate,
                               input logic known_found);
        beat_result_t res;
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        ir_sample <= sample;
        time_ms   <= stamp;
        do
            @(posedge clk);
        while (!in_ready);
        res = detect_beat(sample, stamp);
        if (known)
        begin
            res.rate  = known_rate;
            res.found = known_found;
        end
        expected_beats.push_back(res);
        items_sent++;
    endtask

    // Result side: random stalls, plus one long hold-off on request.
    initial
    begin
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(posedge clk);
                hold_req = 1'b0;
            end
            else
            begin
                out_ready <= ($urandom_range(99) >= idle_pct);
            end
        end
    end

    // Result checker.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_beats.size() == 0)
            begin
                $error("result with no sample pending: rate_bpm=%0d beat_found=%0b",
                       rate_bpm, beat_found);
                fail_count++;
            end
            else
            begin
                head_beat = expected_beats.pop_front();
                if (rate_bpm !== head_beat.rate)
                begin
                    $error("rate_bpm: expected %0d, got %0d", head_beat.rate, rate_bpm);
                    fail_count++;
                end
                if (beat_found !== head_beat.found)
                begin
                    $error("beat_found: expected %0b, got %0b", head_beat.found, beat_found);
                    fail_count++;
                end
                if (beat_found === 1'b1)
                begin
                    beats_seen++;
                end
            end
        end
    end

    // Watchdog.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("Timeout after %0d cycles with %0d results pending.",
                     cycle_count, expected_beats.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    // Main stimulus: reset, directed rows, then random phases under several settings.
    initial
    begin
        logic [athr_pkg::CFG_DATA_W-1:0] set_presence;
        logic [athr_pkg::CFG_DATA_W-1:0] set_min;
        logic [athr_pkg::CFG_DATA_W-1:0] set_max;
        logic [athr_pkg::SAMPLE_W-1:0]   sample;
        logic [athr_pkg::SAMPLE_W-1:0]   floor_level;
        logic [athr_pkg::TIME_W-1:0]     stamp;
        int unsigned                     phase_items;
        int unsigned                     gap_lo;
        int unsigned                     gap_hi;
        int unsigned                     pick;

        rst_n       = 1'b0;
        cfg_valid   = 1'b0;
        cfg_index   = athr_pkg::CFG_PRESENCE;
        cfg_data    = '0;
        in_valid    = 1'b0;
        ir_sample   = '0;
        time_ms     = '0;
        cycle_count = 0;
        fail_count  = 0;
        items_sent  = 0;
        beats_seen  = 0;
        reg_writes  = 0;
        idle_pct    = 8;
        hold_req    = 1'b0;

        presence_cfg = athr_pkg::PRESENCE_RST;
        min_gap_cfg  = athr_pkg::MIN_IVAL_RST;
        max_gap_cfg  = athr_pkg::MAX_IVAL_RST;
        thr_level    = athr_pkg::THRESHOLD_RST;
        last_beat    = '0;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part.
        foreach (directed_rows[r])
        begin
            if (directed_rows[r].kind == ROW_REG)
            begin
                write_reg(directed_rows[r].idx, directed_rows[r].value);
            end
            else
            begin
                push_sample(directed_rows[r].value, directed_rows[r].stamp,
                            directed_rows[r].known, directed_rows[r].rate,
                            directed_rows[r].found);
            end
        end

        // Random part, one register setting per phase.
        for (int p = 0; p < PHASES; p++)
        begin
            phase_items = 175;
            idle_pct    = 8;
            case (p)
                0:
                begin
                    set_presence = athr_pkg::PRESENCE_RST;
                    set_min      = athr_pkg::MIN_IVAL_RST;
                    set_max      = athr_pkg::MAX_IVAL_RST;
                end
                1:
                begin
                    // Widest window, lowest presence level, no idling on either side.
                    set_presence = '0;
                    set_min      = '0;
                    set_max      = 18'd65535;
                    idle_pct     = 0;
                end
                2:
                begin
                    // No sample can show a finger.
                    set_presence = SAMPLE_MAX;
                    set_min      = athr_pkg::MIN_IVAL_RST;
                    set_max      = athr_pkg::MAX_IVAL_RST;
                    phase_items  = 60;
                end
                3:
                begin
                    // Only an interval of one passes, for the top rate.
                    set_presence = 18'd1000;
                    set_min      = '0;
                    set_max      = 18'd2;
                end
                4:
                begin
                    // Minimum above maximum: nothing passes.
                    set_presence = 18'd30000;
                    set_min      = 18'd2000;
                    set_max      = 18'd300;
                end
                5:
                begin
                    set_presence = 18'd100;
                    set_min      = SAMPLE_MAX;
                    set_max      = SAMPLE_MAX;
                end
                default:
                begin
                    set_presence = cfg_word_t'($urandom_range(120000));
                    set_min      = cfg_word_t'($urandom_range(600, 100));
                    set_max      = set_min + cfg_word_t'($urandom_range(3000, 200));
                end
            endcase
            write_reg(athr_pkg::CFG_MAX_IVAL, set_max);
            write_reg(athr_pkg::CFG_PRESENCE, set_presence);
            write_reg(athr_pkg::CFG_MIN_IVAL, set_min);

            for (int i = 0; i < phase_items; i++)
            begin
                // Long hold-off on the result side while samples keep coming.
                if (p == 6 && i == 20)
                begin
                    hold_req = 1'b1;
                end
                // Pause offering until every pending result has come out.
                if (p == 0 && i == 80)
                begin
                    drain_results();
                end

                // Sample: peak above the threshold, trough, absent or raw.
                floor_level = (thr_level > presence_cfg) ? thr_level : presence_cfg;
                pick = $urandom_range(99);
                if (pick < 10)
                begin
                    sample = sample_t'($urandom_range(presence_cfg));
                end
                else if (pick < 20 || (pick >= 40 && floor_level == SAMPLE_MAX))
                begin
                    sample = sample_t'($urandom_range(SAMPLE_MAX));
                end
                else if (pick < 40)
                begin
                    if (presence_cfg < thr_level)
                        sample = sample_t'($urandom_range(thr_level, presence_cfg + 1));
                    else
                        sample = sample_t'($urandom_range(SAMPLE_MAX));
                end
                else
                begin
                    sample = sample_t'($urandom_range(SAMPLE_MAX, floor_level + 1));
                end

                // Time: mostly an interval near the window, some at its edges, some raw.
                gap_hi = ((min_gap_cfg > max_gap_cfg) ? min_gap_cfg : max_gap_cfg) + 3;
                gap_lo = (min_gap_cfg > 3) ? min_gap_cfg - 3 : 0;
                pick = $urandom_range(99);
                if (pick < 8)
                begin
                    stamp = $urandom();
                end
                else if (pick < 18)
                begin
                    case ($urandom_range(3))
                        0: stamp = last_beat + min_gap_cfg;
                        1: stamp = last_beat + min_gap_cfg + 1;
                        2: stamp = last_beat + max_gap_cfg - 1;
                        default: stamp = last_beat + max_gap_cfg;
                    endcase
                end
                else
                begin
                    stamp = last_beat + $urandom_range(gap_hi, gap_lo);
                end

                push_sample(sample, stamp, 1'b0, '0, 1'b0);
            end
        end

        // Wind down: everything out, then a DRAIN_CYCLES wait for strays.
        drain_results();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Ran %0d samples through %0d register writes and %0d settings;",
                 items_sent, reg_writes, PHASES + 1);
        $display("%0d beats reported, %0d mismatches.", beats_seen, fail_count);
        if (fail_count == 0)
        begin
            $display("== PASS ==");
        end
        else
        begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
